// ----- rtl/protobuf_wire_value_decoder_core_macros.svh -----
// Assertion macros used by the wire value decoder result queue.
`ifndef PROTOBUF_WIRE_VALUE_DECODER_CORE_MACROS_SVH
`define PROTOBUF_WIRE_VALUE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WVD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define WVD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wvd_pkg.sv -----
// Types and constants of the protobuf wire value decoder.
package wvd_pkg;

	typedef enum logic [2:0] {
		K_VARINT32 = 3'd0,
		K_VARINT64 = 3'd1,
		K_FIXED32  = 3'd2,
		K_FIXED64  = 3'd3,
		K_BOOL     = 3'd4,
		K_LENDELIM = 3'd5,
		K_PAYLOAD  = 3'd6,
		K_IDLE     = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_PAST_END   = 2'd1,
		ST_MALFORMED  = 2'd2,
		ST_BAD_LENGTH = 2'd3
	} status_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_payload;
		logic        last;
		status_t     status;
	} res_t;

	localparam int WVD_QUEUE_DEPTH = 2;
	localparam int LEN_W = 31;
	localparam logic [3:0] V32_FULL_BYTES = 4'd4;
	localparam logic [3:0] V32_MAX_BYTES = 4'd5;
	localparam logic [2:0] V32_MAX_DISCARD = 3'd5;
	localparam logic [3:0] V64_MAX_BYTES = 4'd10;
	localparam logic [3:0] F32_BYTES = 4'd4;
	localparam logic [3:0] F64_BYTES = 4'd8;

endpackage

// ----- rtl/protobuf_wire_value_decoder_core.sv -----
// Top level of the protobuf wire value decoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | in_valid / in_ready    | opcode, data_byte
//  output   | out_valid / out_ready  | value, is_payload, last, status
//  config   | cfg_we                 | cfg_data (buffer_length)
//
// One byte request is taken per cycle while in_ready is high; its decode finishes in the cycle it is taken.
// A result passes through the result queue and then the output register before it appears on the output.
// in_ready follows free space in the result queue (QUEUE_DEPTH entries).
// Output stalls fill the queue; the input stalls only once it is full.
// Reset clears the decode state and buffer_length, and leaves no value in progress.
module protobuf_wire_value_decoder_core
	import wvd_pkg::*;
#(
	parameter int QUEUE_DEPTH = WVD_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       opcode,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [63:0]      value,
	output logic             is_payload,
	output logic             last,
	output logic [1:0]       status,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data
);

	logic accept, push, pop, q_valid, space;
	res_t res, q_head;

	assign in_ready = space;
	assign accept   = in_valid && space;

	wvd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push      (push),
		.res       (res)
	);

	wvd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_valid),
		.space     (space)
	);

	wvd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.value      (value),
		.is_payload (is_payload),
		.last       (last),
		.status     (status)
	);

endmodule

// ----- rtl/wvd_front.sv -----
// Front end: takes each byte request, updates the decode state and forms results.
module wvd_front
	import wvd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       opcode,
	input  logic [7:0]       data_byte,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	output logic             push,
	output res_t             res
);

	logic [LEN_W-1:0] blen_q, pos_q, rem_q;
	logic [63:0]      acc_q;
	logic [3:0]       cnt_q;
	kind_t            kind_q;
	logic [2:0]       disc_q;
	logic             past_q;
	status_t          pstat_q;

	logic [LEN_W-1:0] pos_d, rem_d, pos_rd, rem_n;
	logic [63:0]      acc_d, acc_c, acc_or;
	logic [3:0]       cnt_d, cnt_c, cnt_inc;
	kind_t            kind_d, kind_c;
	logic [2:0]       disc_d, disc_c;
	logic             past_d, past_c, past_rd;
	status_t          pstat_d, pstat_c, fin_st, st;
	logic             start, skip, pe, fin, size_ok;
	logic [7:0]       b, grp;
	logic [6:0]       m7;
	logic [5:0]       sh;
	logic [31:0]      v, room;

	assign start = (kind_q == K_IDLE);
	assign skip  = start && (opcode > 3'(K_LENDELIM));

	assign kind_c  = start ? kind_t'(opcode) : kind_q;
	assign acc_c   = start ? '0 : acc_q;
	assign cnt_c   = start ? '0 : cnt_q;
	assign disc_c  = start ? '0 : disc_q;
	assign past_c  = start ? 1'b0 : past_q;
	assign pstat_c = start ? ST_OK : pstat_q;

	assign pe      = (pos_q >= blen_q);
	assign b       = pe ? 8'h00 : data_byte;
	assign pos_rd  = pe ? pos_q : pos_q + 1'b1;
	assign past_rd = past_c | pe;

	assign m7 = {cnt_c, 3'b000} - {3'b000, cnt_c};

	always_comb begin
		case (kind_c)
			K_VARINT64: begin
				grp = {1'b0, b[6:0]};
				sh  = m7[5:0];
			end
			K_FIXED32, K_FIXED64: begin
				grp = b;
				sh  = {cnt_c[2:0], 3'b000};
			end
			default: begin
				grp = (cnt_c < V32_FULL_BYTES) ? {1'b0, b[6:0]} : {4'b0000, b[3:0]};
				sh  = m7[5:0];
			end
		endcase
	end

	assign acc_or  = acc_c | ({56'd0, grp} << sh);
	assign cnt_inc = cnt_c + 1'b1;
	assign rem_n   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	assign v       = (cnt_c >= V32_MAX_BYTES) ? acc_c[31:0] : acc_or[31:0];
	assign room    = {1'b0, blen_q} - {1'b0, pos_rd};
	assign size_ok = !v[31] && !room[31] && (v <= room);

	always_comb begin
		pos_d   = pos_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		kind_d  = kind_q;
		disc_d  = disc_q;
		past_d  = past_q;
		pstat_d = pstat_q;
		push    = 1'b0;
		res     = '0;
		fin     = 1'b0;
		fin_st  = ST_OK;
		st      = ST_OK;
		if (accept && !skip) begin
			pos_d   = pos_rd;
			past_d  = past_rd;
			kind_d  = kind_c;
			acc_d   = acc_c;
			cnt_d   = cnt_c;
			disc_d  = disc_c;
			pstat_d = pstat_c;
			case (kind_c)
				K_VARINT32, K_BOOL, K_LENDELIM: begin
					if (cnt_c >= V32_MAX_BYTES) begin
						disc_d = disc_c + 1'b1;
						if (!b[7]) begin
							fin = 1'b1;
						end else if (disc_d >= V32_MAX_DISCARD) begin
							fin    = 1'b1;
							fin_st = ST_MALFORMED;
						end
					end else begin
						acc_d = acc_or;
						cnt_d = cnt_inc;
						fin   = !b[7];
					end
					if (fin) begin
						st     = past_rd ? ST_PAST_END : fin_st;
						kind_d = K_IDLE;
						if (kind_c == K_VARINT32) begin
							push = 1'b1;
							res  = '{value: {32'd0, v}, is_payload: 1'b0, last: 1'b1, status: st};
						end else if (kind_c == K_BOOL) begin
							push = 1'b1;
							res  = '{value: {63'd0, v != '0}, is_payload: 1'b0, last: 1'b1,
								status: st};
						end else if (v == '0) begin
							push = 1'b1;
							res  = '{value: '0, is_payload: 1'b1, last: 1'b1, status: st};
						end else if (size_ok) begin
							rem_d   = v[LEN_W-1:0];
							pstat_d = st;
							kind_d  = K_PAYLOAD;
						end else begin
							push = 1'b1;
							res  = '{value: '0, is_payload: 1'b0, last: 1'b1,
								status: ST_BAD_LENGTH};
						end
					end
				end
				K_VARINT64: begin
					acc_d = acc_or;
					cnt_d = cnt_inc;
					if (!b[7]) begin
						kind_d = K_IDLE;
						push   = 1'b1;
						res    = '{value: acc_or, is_payload: 1'b0, last: 1'b1,
							status: past_rd ? ST_PAST_END : ST_OK};
					end else if (cnt_inc >= V64_MAX_BYTES) begin
						kind_d = K_IDLE;
						push   = 1'b1;
						res    = '{value: '0, is_payload: 1'b0, last: 1'b1,
							status: past_rd ? ST_PAST_END : ST_MALFORMED};
					end
				end
				K_FIXED32, K_FIXED64: begin
					acc_d = acc_or;
					cnt_d = cnt_inc;
					if (cnt_inc >= ((kind_c == K_FIXED32) ? F32_BYTES : F64_BYTES)) begin
						kind_d = K_IDLE;
						push   = 1'b1;
						res    = '{value: acc_or, is_payload: 1'b0, last: 1'b1,
							status: past_rd ? ST_PAST_END : ST_OK};
					end
				end
				default: begin
					rem_d = rem_n;
					if (rem_n == '0) begin
						kind_d = K_IDLE;
					end
					push = 1'b1;
					res  = '{value: {56'd0, b}, is_payload: 1'b1, last: rem_n == '0,
						status: past_rd ? ST_PAST_END : pstat_c};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q  <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			kind_q  <= K_IDLE;
			disc_q  <= '0;
			past_q  <= 1'b0;
			pstat_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				blen_q <= cfg_data;
			end
			pos_q   <= pos_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
			disc_q  <= disc_d;
			past_q  <= past_d;
			pstat_q <= pstat_d;
		end
	end

endmodule

// ----- rtl/wvd_queue.sv -----
// Result queue between the front end and the output stage.
`include "protobuf_wire_value_decoder_core_macros.svh"
module wvd_queue
	import wvd_pkg::*;
#(
	parameter int DEPTH = WVD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output res_t head,
	output logic not_empty,
	output logic space
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign space     = (cnt_q != CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`WVD_ASSERT_NOW(a_no_overflow, push, cnt_q != CNT_W'(DEPTH), "push into full queue")
	`WVD_ASSERT_NOW(a_no_underflow, pop, cnt_q != '0, "pop from empty queue")
	`WVD_ASSERT_NEXT(a_count_up, push && !pop, cnt_q == $past(cnt_q) + CNT_W'(1), "count lost a push")
	`WVD_ASSERT_NOW(a_empty_ptrs, cnt_q == '0, wr_q == rd_q, "empty queue with split pointers")

endmodule

// ----- rtl/wvd_back.sv -----
// Output stage: holds one result until the consumer takes it.
module wvd_back
	import wvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  res_t        q_head,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] value,
	output logic        is_payload,
	output logic        last,
	output logic [1:0]  status
);

	logic out_valid_q;
	res_t out_q;

	assign pop        = q_valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign value      = out_q.value;
	assign is_payload = out_q.is_payload;
	assign last       = out_q.last;
	assign status     = out_q.status;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
